@@ rtl/poel_pkg.sv @@
// Shared types and constants for the priority ordered entry list.
package poel_pkg;

  localparam int unsigned DEF_CAPACITY = 32;
  localparam int unsigned ID_W         = 8;
  localparam int unsigned LEVEL_W      = 16;

  typedef enum logic [1:0] {
    OP_ADD       = 2'd0,
    OP_REMOVE    = 2'd1,
    OP_SET_LEVEL = 2'd2,
    OP_LIST      = 2'd3
  } op_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_RELEVEL,
    ST_LIST
  } state_e;

  typedef enum logic [1:0] {
    CMD_HOLD,
    CMD_INSERT,
    CMD_REMOVE,
    CMD_ROTATE
  } cell_cmd_e;

  typedef struct packed {
    op_e                operation;
    logic [ID_W-1:0]    entry_id;
    logic [LEVEL_W-1:0] priority_level;
  } in_t;

  typedef struct packed {
    logic               success;
    logic               entry_valid;
    logic [ID_W-1:0]    out_id;
    logic [LEVEL_W-1:0] out_level;
    logic               last;
  } out_t;

  typedef struct packed {
    logic [ID_W-1:0]    id;
    logic [LEVEL_W-1:0] level;
  } entry_t;

  // Where a cell sits relative to the fill level of the chain.
  typedef struct packed {
    logic occ;     // holds a live entry
    logic tail;    // last live entry
    logic open;    // first free slot
  } cell_pos_t;

endpackage

@@ rtl/poel_cell.sv @@
// One slot of the sorted chain: holds an entry, inserts, closes gaps, rotates.
module poel_cell
  import poel_pkg::*;
(
  input  logic      clk_i,
  input  cell_cmd_e cmd_i,
  input  entry_t    key_i,
  input  cell_pos_t pos_i,
  input  logic      prev_gt_i,
  input  logic      prev_seen_i,
  input  entry_t    left_i,
  input  entry_t    right_i,
  input  entry_t    head_i,
  output logic      gt_o,
  output logic      seen_o,
  output entry_t    entry_o
);

  entry_t entry_q, entry_d;

  assign gt_o    = pos_i.occ && (entry_q.level > key_i.level);
  assign seen_o  = prev_seen_i || (pos_i.occ && (entry_q.id == key_i.id));
  assign entry_o = entry_q;

  always_comb begin
    entry_d = entry_q;
    case (cmd_i)
      CMD_INSERT: begin
        // greater levels move one place down; the new entry lands ahead of them
        if (prev_gt_i) begin
          entry_d = left_i;
        end else if (gt_o || pos_i.open) begin
          entry_d = key_i;
        end
      end
      CMD_REMOVE: begin
        if (seen_o) begin
          entry_d = right_i;
        end
      end
      CMD_ROTATE: begin
        if (pos_i.tail) begin
          entry_d = head_i;
        end else if (pos_i.occ) begin
          entry_d = right_i;
        end
      end
      default: entry_d = entry_q;
    endcase
  end

  always_ff @(posedge clk_i) begin
    entry_q <= entry_d;
  end

endmodule

@@ rtl/priority_ordered_entry_list.sv @@
// Top level of the priority ordered entry list: cell chain and sequencer.
//
//   channel  dir  handshake                 payload
//   in       in   in_valid_i / in_ready_o   in_data_i  (in_t)
//   out      out  out_valid_o / out_ready_i out_data_o (out_t)
//
// Add and remove: result beat registered at the accept edge.
// Set level: removal at the accept edge, re-insertion once the output register is free.
// List: one beat per cycle after the accept cycle while the output is not stalled, CAPACITY beats at most;
//   the chain rotates by one place per beat and is back in order at the end.
// Reset clears the fill count and the sequencer; slot contents stay undefined.
// A stalled output beat holds the sequencer; no new beat is taken until the
//   output register is free.
module priority_ordered_entry_list
  import poel_pkg::*;
#(
  parameter int unsigned CAPACITY = DEF_CAPACITY
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic in_valid_i,
  output logic in_ready_o,
  input  in_t  in_data_i,
  output logic out_valid_o,
  input  logic out_ready_i,
  output out_t out_data_o
);

  localparam int unsigned CNT_W = $clog2(CAPACITY + 1);

  state_e           state_q, state_d;
  logic [CNT_W-1:0] count_q, count_d;   // live entries
  logic [CNT_W-1:0] rem_q, rem_d;       // list beats still to send
  entry_t           pend_q, pend_d;     // entry awaiting re-insertion
  logic             out_valid_q, out_valid_d;
  out_t             out_data_q, out_data_d;
  logic             out_load;

  cell_cmd_e        cmd;
  entry_t           key;
  logic             out_free;
  logic             in_accept;
  logic             found;

  logic      [CAPACITY-1:0] gt;
  logic      [CAPACITY-1:0] seen;
  entry_t    [CAPACITY-1:0] ent;
  cell_pos_t [CAPACITY-1:0] pos;

  assign out_free   = !out_valid_q || out_ready_i;
  assign in_ready_o = (state_q == ST_IDLE) && out_free;
  assign in_accept  = in_valid_i && in_ready_o;

  // Key for compares: the pending entry while re-levelling, else the incoming beat.
  assign key = (state_q == ST_RELEVEL) ? pend_q
                                       : entry_t'{id: in_data_i.entry_id,
                                                  level: in_data_i.priority_level};

  // Set when any slot in the live part of the chain holds a matching id.
  assign found = seen[CAPACITY-1];

  // ---------------------------------------------------------------------------
  // Cell chain. The compare results ripple from slot 0 downwards, data moves
  // one slot either way; on a rotate the head entry wraps round to the tail.
  // ---------------------------------------------------------------------------
  for (genvar k = 0; k < CAPACITY; k++) begin : g_cell
    logic   prev_gt;
    logic   prev_seen;
    entry_t left;
    entry_t right;

    assign pos[k].occ  = CNT_W'(k) < count_q;
    assign pos[k].tail = CNT_W'(k + 1) == count_q;
    assign pos[k].open = CNT_W'(k) == count_q;

    if (k == 0) begin : g_head
      assign prev_gt   = 1'b0;
      assign prev_seen = 1'b0;
      assign left      = key;
    end else begin : g_body
      assign prev_gt   = gt[k-1];
      assign prev_seen = seen[k-1];
      assign left      = ent[k-1];
    end

    if (k == CAPACITY - 1) begin : g_end
      assign right = key;
    end else begin : g_mid
      assign right = ent[k+1];
    end

    poel_cell u_cell (
      .clk_i       (clk_i),
      .cmd_i       (cmd),
      .key_i       (key),
      .pos_i       (pos[k]),
      .prev_gt_i   (prev_gt),
      .prev_seen_i (prev_seen),
      .left_i      (left),
      .right_i     (right),
      .head_i      (ent[0]),
      .gt_o        (gt[k]),
      .seen_o      (seen[k]),
      .entry_o     (ent[k])
    );
  end

  // ---------------------------------------------------------------------------
  // Sequencer: next state
  // ---------------------------------------------------------------------------
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (in_accept && (in_data_i.operation == OP_SET_LEVEL) && found) begin
          state_d = ST_RELEVEL;
        end else if (in_accept && (in_data_i.operation == OP_LIST) &&
                     (count_q != '0)) begin
          state_d = ST_LIST;
        end
      end
      ST_RELEVEL: begin
        if (out_free) begin
          state_d = ST_IDLE;
        end
      end
      ST_LIST: begin
        if (out_free && (rem_q == CNT_W'(1))) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // ---------------------------------------------------------------------------
  // Sequencer: chain command, counters and result beat
  // ---------------------------------------------------------------------------
  always_comb begin
    cmd        = CMD_HOLD;
    count_d    = count_q;
    rem_d      = rem_q;
    pend_d     = pend_q;
    out_load   = 1'b0;
    out_data_d = '{success: 1'b0, entry_valid: 1'b0, out_id: '0, out_level: '0,
                   last: 1'b1};
    unique case (state_q)
      ST_IDLE: begin
        if (in_accept) begin
          unique case (in_data_i.operation)
            OP_ADD: begin
              out_load = 1'b1;
              if (count_q < CNT_W'(CAPACITY)) begin
                cmd                = CMD_INSERT;
                count_d            = count_q + CNT_W'(1);
                out_data_d.success = 1'b1;
              end
            end
            OP_REMOVE: begin
              cmd                = CMD_REMOVE;
              out_load           = 1'b1;
              out_data_d.success = found;
              if (found) begin
                count_d = count_q - CNT_W'(1);
              end
            end
            OP_SET_LEVEL: begin
              cmd = CMD_REMOVE;
              if (found) begin
                count_d = count_q - CNT_W'(1);
                pend_d  = key;
              end else begin
                out_load = 1'b1;
              end
            end
            OP_LIST: begin
              rem_d = count_q;
              if (count_q == '0) begin
                out_load           = 1'b1;
                out_data_d.success = 1'b1;
              end
            end
            default: cmd = CMD_HOLD;
          endcase
        end
      end
      ST_RELEVEL: begin
        // the removal freed a slot, so this insert cannot fail
        if (out_free) begin
          cmd                = CMD_INSERT;
          count_d            = count_q + CNT_W'(1);
          out_load           = 1'b1;
          out_data_d.success = 1'b1;
        end
      end
      ST_LIST: begin
        if (out_free) begin
          cmd                    = CMD_ROTATE;
          rem_d                  = rem_q - CNT_W'(1);
          out_load               = 1'b1;
          out_data_d.success     = 1'b1;
          out_data_d.entry_valid = 1'b1;
          out_data_d.out_id      = ent[0].id;
          out_data_d.out_level   = ent[0].level;
          out_data_d.last        = (rem_q == CNT_W'(1));
        end
      end
      default: cmd = CMD_HOLD;
    endcase
  end

  assign out_valid_d = out_load || (out_valid_q && !out_ready_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      count_q     <= '0;
      rem_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      count_q     <= count_d;
      rem_q       <= rem_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    pend_q <= pend_d;
    if (out_load) begin
      out_data_q <= out_data_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

  // ---------------------------------------------------------------------------
  // Assertions
  // ---------------------------------------------------------------------------
  a_count_range : assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CNT_W'(CAPACITY))
    else $error("fill count beyond capacity");

  a_full_add_keeps : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_accept && (in_data_i.operation == OP_ADD) && (count_q == CNT_W'(CAPACITY)))
    |=> $stable(count_q))
    else $error("add on a full table changed the fill count");

  a_list_keeps_count : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_LIST) |=> $stable(count_q))
    else $error("fill count moved during a list");

  a_relevel_has_room : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_RELEVEL) |-> (count_q < CNT_W'(CAPACITY)))
    else $error("re-insertion with no free slot");

  a_list_rem_range : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_LIST) |-> ((rem_q != '0) && (rem_q <= count_q)))
    else $error("list beat counter out of range");

endmodule
